@@ sv/frfifo_pkg.sv @@
// ----------------------------------------------------------------------------
// frfifo_pkg
// Shared types and codes for the frame ring byte fifo: transaction payloads,
// request codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package frfifo_pkg;

  // request codes carried in the cmd field
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // input transaction
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] wr_byte;
    logic [6:0] frame_len;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [6:0] done_count;
    logic       is_empty;
    logic [7:0] available;
    logic       frame_ready;
    logic       last;
  } out_t;

  // kinds of work handed to the back end
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SINGLE,
    KIND_STREAM
  } kind_t;

  // front-to-back command
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [6:0] len;
    logic       report;
    logic       adv;
    logic       is_empty;
    logic [7:0] available;
    logic       frame_ready;
  } cmd_t;

endpackage

@@ sv/frfifo_cmdq.sv @@
// ----------------------------------------------------------------------------
// frfifo_cmdq
// Four-entry command queue between the classifying front end and the
// executing back end.
// ----------------------------------------------------------------------------
module frfifo_cmdq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  frfifo_pkg::cmd_t    push_data,
  output logic                full,
  input  logic                pop,
  output frfifo_pkg::cmd_t    pop_data,
  output logic                empty
);

  localparam int N = 4;

  frfifo_pkg::cmd_t ent_r [N];
  logic [1:0]       wr_r;
  logic [1:0]       rd_r;
  logic [2:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == 3'(N));
  assign empty    = (cnt_r == 3'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = ent_r[rd_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 2'd1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 2'd1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 3'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 3'd1;
      end
    end
  end

endmodule

@@ sv/frfifo_front.sv @@
// ----------------------------------------------------------------------------
// frfifo_front
// Accepts request transactions, tracks committed pointers and the write frame
// in progress, and turns each request into back-end commands.
// ----------------------------------------------------------------------------
module frfifo_front #(
  parameter int DEPTH     = 256,
  parameter int MAX_FRAME = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  frfifo_pkg::in_t   in_data,
  output logic              full,
  output logic              cq_push,
  output frfifo_pkg::cmd_t  cq_data,
  input  logic              cq_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = (AW + 1 > 8) ? AW + 1 : 8;

  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [6:0]    off_r;
  logic [6:0]    latch_r;
  logic          drop_r;

  logic [AW-1:0] wp_nxt;
  logic [AW-1:0] rp_nxt;
  logic [6:0]    off_nxt;
  logic [6:0]    latch_nxt;
  logic          drop_nxt;

  logic          accept;
  logic [SW-1:0] avail;
  logic [SW-1:0] free_sp;
  logic [SW-1:0] len_x;
  logic          first;
  logic [6:0]    eff_len;
  logic          eff_drop;
  logic [6:0]    off_inc;
  logic          is_last;
  logic          need_enq;
  logic [6:0]    rd_len;

  // pointer advance modulo the ring size
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p, input logic [6:0] inc);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(inc);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full   = cq_full;
  assign accept = push && !cq_full;

  // stored count and free space
  always_comb begin
    if (wp_r >= rp_r) begin
      avail = SW'(wp_r) - SW'(rp_r);
    end else begin
      avail = SW'(wp_r) + SW'(DEPTH) - SW'(rp_r);
    end
    free_sp = SW'(DEPTH - 1) - avail;
    len_x   = SW'(in_data.frame_len);
  end

  // write frame bookkeeping
  always_comb begin
    first    = (off_r == 7'd0);
    eff_len  = first ? in_data.frame_len : latch_r;
    eff_drop = first ? ((in_data.frame_len > 7'(MAX_FRAME)) || (free_sp < len_x)) : drop_r;
    off_inc  = off_r + 7'd1;
    is_last  = (off_inc >= eff_len);
  end

  // classify the request into a command and next pointer state
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    off_nxt   = off_r;
    latch_nxt = latch_r;
    drop_nxt  = drop_r;
    need_enq  = 1'b0;
    rd_len    = in_data.frame_len;
    cq_data   = '0;
    cq_data.kind = frfifo_pkg::KIND_SINGLE;
    unique case (in_data.cmd)
      frfifo_pkg::OP_WRITE: begin
        if (first && (in_data.frame_len == 7'd0)) begin
          need_enq = 1'b1;
        end else begin
          if (!eff_drop) begin
            need_enq       = 1'b1;
            cq_data.kind   = frfifo_pkg::KIND_WRITE;
            cq_data.data   = in_data.wr_byte;
            cq_data.len    = eff_len;
            cq_data.report = is_last;
          end else if (is_last) begin
            need_enq = 1'b1;
          end
          if (is_last) begin
            off_nxt  = 7'd0;
            drop_nxt = 1'b0;
            if (!eff_drop) begin
              wp_nxt = ring_add(wp_r, eff_len);
            end
          end else begin
            off_nxt   = off_inc;
            latch_nxt = eff_len;
            drop_nxt  = eff_drop;
          end
        end
      end
      frfifo_pkg::OP_STATUS: begin
        need_enq            = 1'b1;
        cq_data.is_empty    = (wp_r == rp_r);
        cq_data.available   = (avail > SW'(255)) ? 8'hFF : avail[7:0];
        cq_data.frame_ready = (avail >= len_x);
      end
      frfifo_pkg::OP_READ, frfifo_pkg::OP_PEEK: begin
        need_enq = 1'b1;
        if ((in_data.frame_len != 7'd0) && (in_data.frame_len <= 7'(MAX_FRAME))) begin
          priority if (avail >= len_x) begin
            cq_data.kind = frfifo_pkg::KIND_STREAM;
          end else if ((in_data.cmd == frfifo_pkg::OP_PEEK) && (avail != '0)) begin
            cq_data.kind = frfifo_pkg::KIND_STREAM;
            rd_len       = avail[6:0];
          end else begin
            cq_data.kind = frfifo_pkg::KIND_SINGLE;
          end
          if (cq_data.kind == frfifo_pkg::KIND_STREAM) begin
            cq_data.len = rd_len;
            cq_data.adv = (in_data.cmd == frfifo_pkg::OP_READ);
            if (in_data.cmd == frfifo_pkg::OP_READ) begin
              rp_nxt = ring_add(rp_r, rd_len);
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign cq_push = accept && need_enq;

  // committed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      off_r   <= '0;
      latch_r <= '0;
      drop_r  <= 1'b0;
    end else if (accept) begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      off_r   <= off_nxt;
      latch_r <= latch_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

@@ sv/frfifo_back.sv @@
// ----------------------------------------------------------------------------
// frfifo_back
// Executes commands: writes frame bytes into the ring store, streams read and
// peek frames out of it, and queues result transactions for the consumer.
// ----------------------------------------------------------------------------
module frfifo_back #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  frfifo_pkg::cmd_t  cq_data,
  input  logic              cq_empty,
  output logic              cq_pop,
  output frfifo_pkg::out_t  out_data,
  output logic              empty,
  input  logic              pop
);

  localparam int AW = $clog2(DEPTH);
  localparam int OD = 4;

  // ring store
  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q_r;

  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW-1:0]    cur_r;
  logic [6:0]       left_r;
  logic [6:0]       slen_r;
  logic             adv_r;
  logic             act_r;

  logic             stg_v_r;
  logic             stg_mem_r;
  frfifo_pkg::out_t stg_meta_r;

  frfifo_pkg::out_t oq_r [OD];
  logic [1:0]       ow_r;
  logic [1:0]       or_r;
  logic [2:0]       ocnt_r;

  logic             space;
  logic             rd_en;
  logic             wr_en;
  logic             iss;
  logic             iss_mem;
  frfifo_pkg::out_t iss_meta;
  frfifo_pkg::out_t push_res;
  logic             o_pop;

  function automatic logic [AW-1:0] inc1(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // room for one more result counting the one in the read stage
  assign space = ((ocnt_r + 3'(stg_v_r)) < 3'(OD));

  // pick this cycle's work: a stream beat or the next command
  always_comb begin
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    cq_pop   = 1'b0;
    iss      = 1'b0;
    iss_mem  = 1'b0;
    iss_meta = '0;
    if (act_r) begin
      if (space) begin
        rd_en               = 1'b1;
        iss                 = 1'b1;
        iss_mem             = 1'b1;
        iss_meta.byte_valid = 1'b1;
        iss_meta.done_count = slen_r;
        iss_meta.last       = (left_r == 7'd1);
      end
    end else if (!cq_empty && space) begin
      cq_pop = 1'b1;
      unique case (cq_data.kind)
        frfifo_pkg::KIND_WRITE: begin
          wr_en = 1'b1;
          if (cq_data.report) begin
            iss                 = 1'b1;
            iss_meta.done_count = cq_data.len;
            iss_meta.last       = 1'b1;
          end
        end
        frfifo_pkg::KIND_SINGLE: begin
          iss                  = 1'b1;
          iss_meta.is_empty    = cq_data.is_empty;
          iss_meta.available   = cq_data.available;
          iss_meta.frame_ready = cq_data.frame_ready;
          iss_meta.last        = 1'b1;
        end
        frfifo_pkg::KIND_STREAM: ;
        default: ;
      endcase
    end
  end

  // store write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= cq_data.data;
    end
  end

  // store read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[cur_r];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (iss) begin
      stg_meta_r <= iss_meta;
      stg_mem_r  <= iss_mem;
    end
  end

  // pointers, stream sequencing and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cur_r    <= '0;
      left_r   <= '0;
      slen_r   <= '0;
      adv_r    <= 1'b0;
      act_r    <= 1'b0;
      stg_v_r  <= 1'b0;
    end else begin
      stg_v_r <= iss;
      if (wr_en) begin
        wr_ptr_r <= inc1(wr_ptr_r);
      end
      if (cq_pop && (cq_data.kind == frfifo_pkg::KIND_STREAM)) begin
        act_r  <= 1'b1;
        cur_r  <= rd_ptr_r;
        left_r <= cq_data.len;
        slen_r <= cq_data.len;
        adv_r  <= cq_data.adv;
      end
      if (rd_en) begin
        cur_r  <= inc1(cur_r);
        left_r <= left_r - 7'd1;
        if (left_r == 7'd1) begin
          act_r <= 1'b0;
          if (adv_r) begin
            rd_ptr_r <= inc1(cur_r);
          end
        end
      end
    end
  end

  // merge store data into the staged result
  always_comb begin
    push_res          = stg_meta_r;
    push_res.out_byte = stg_mem_r ? mem_q_r : 8'h00;
  end

  // result queue
  assign o_pop    = pop && (ocnt_r != 3'd0);
  assign empty    = (ocnt_r == 3'd0);
  assign out_data = oq_r[or_r];

  always_ff @(posedge clk) begin
    if (stg_v_r) begin
      oq_r[ow_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ow_r   <= '0;
      or_r   <= '0;
      ocnt_r <= '0;
    end else begin
      if (stg_v_r) begin
        ow_r <= ow_r + 2'd1;
      end
      if (o_pop) begin
        or_r <= or_r + 2'd1;
      end
      if (stg_v_r && !o_pop) begin
        ocnt_r <= ocnt_r + 3'd1;
      end else if (o_pop && !stg_v_r) begin
        ocnt_r <= ocnt_r - 3'd1;
      end
    end
  end

endmodule

@@ sv/frame_ring_byte_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// frame_ring_byte_fifo_unit
// Byte ring buffer of DEPTH slots (DEPTH-1 usable) that moves whole frames.
// ----------------------------------------------------------------------------
// Usage: request transactions enter through push/full with in_data; a write
// frame is frame_len write transactions, checked for room on its first byte
// and dropped whole if it does not fit. Results leave through empty/pop with
// out_data: one result for a status query, a rejection or the last byte of a
// write frame, and one result per byte for a read or peek, with last set on
// the final result of each request.
// Throughput: one request per cycle while the command queue has room; a read
// or peek holds the back end for the whole stream, one store read port
// access per byte. Write bytes take one store write each.
// Path: a single result passes the command queue, the result stage and the
// result queue before it shows on the output; the first byte of a read or
// peek also waits for the stream to start before the store read.
// Reset clears pointers, the frame in progress and both queues; store
// contents are not cleared. When the receiver stalls the result queue fills,
// the back end stops, then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module frame_ring_byte_fifo_unit #(
  parameter int DEPTH     = 256,
  parameter int MAX_FRAME = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  frfifo_pkg::in_t   in_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output frfifo_pkg::out_t  out_data
);

  logic             cq_push;
  frfifo_pkg::cmd_t cq_wdata;
  logic             cq_full;
  logic             cq_pop;
  frfifo_pkg::cmd_t cq_rdata;
  logic             cq_empty;

  // request classification
  frfifo_front #(
    .DEPTH     (DEPTH),
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .cq_push (cq_push),
    .cq_data (cq_wdata),
    .cq_full (cq_full)
  );

  // command queue
  frfifo_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cq_push),
    .push_data (cq_wdata),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_data  (cq_rdata),
    .empty     (cq_empty)
  );

  // execution and result queue
  frfifo_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_data  (cq_rdata),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame ring byte fifo. Request transactions go in
// through push/full, and an in-bench ring predictor computes the result
// transactions for each one. Every popped result is compared field by field
// with the oldest prediction. The run covers directed corner cases, a
// fill-to-capacity pass with dropped frames, and random frame traffic under
// three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RING_DEPTH    = 256;
  localparam int MAX_FRAME_LEN = 64;
  localparam int DRAIN_CYCLES  = 20;

  logic             clk     = 1'b0;
  logic             rst_n   = 1'b0;
  logic             push    = 1'b0;
  frfifo_pkg::in_t  in_data = '0;
  logic             full;
  logic             empty;
  logic             pop     = 1'b0;
  frfifo_pkg::out_t out_data;

  // traffic shaping knobs, percent of cycles
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int mismatches     = 0;

  // predictor copy of the ring and the frame in progress
  logic [7:0] ring_mem [RING_DEPTH];
  int   ring_wr_ptr    = 0;
  int   ring_rd_ptr    = 0;
  int   frame_pos      = 0;
  int   frame_len_held = 0;
  bit   frame_drop     = 1'b0;
  frfifo_pkg::out_t pending_results[$];

  frame_ring_byte_fifo_unit #(
    .DEPTH    (RING_DEPTH),
    .MAX_FRAME(MAX_FRAME_LEN)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // committed bytes in the predicted ring
  function automatic int ring_level();
    return (ring_wr_ptr + RING_DEPTH - ring_rd_ptr) % RING_DEPTH;
  endfunction

  // expected results of one accepted request, queued in order
  function automatic void compute_ring_results(input frfifo_pkg::in_t req);
    int   level;
    int   n;
    frfifo_pkg::out_t res;
    level    = ring_level();
    res      = '0;
    res.last = 1'b1;

    // write byte: latch and room check on the first byte, commit on the last
    if (req.cmd == frfifo_pkg::OP_WRITE) begin
      if (frame_pos == 0) begin
        if (req.frame_len == 7'd0) begin
          pending_results.push_back(res);
          return;
        end
        frame_len_held = int'(req.frame_len);
        frame_drop     = (frame_len_held > MAX_FRAME_LEN) ||
                         (RING_DEPTH - 1 - level < frame_len_held);
      end
      if (!frame_drop)
        ring_mem[(ring_wr_ptr + frame_pos) % RING_DEPTH] = req.wr_byte;
      frame_pos = (frame_pos + 1) % 128;
      if (frame_pos < frame_len_held)
        return;
      frame_pos = 0;
      if (!frame_drop) begin
        ring_wr_ptr    = (ring_wr_ptr + frame_len_held) % RING_DEPTH;
        res.done_count = 7'(frame_len_held);
      end
      frame_drop = 1'b0;
      pending_results.push_back(res);
      return;
    end

    // status query
    if (req.cmd == frfifo_pkg::OP_STATUS) begin
      res.is_empty    = (ring_wr_ptr == ring_rd_ptr);
      res.available   = 8'((level > 255) ? 255 : level);
      res.frame_ready = (level >= int'(req.frame_len));
      pending_results.push_back(res);
      return;
    end

    // read or peek: reject bad lengths, a short read, or a peek of nothing
    n = int'(req.frame_len);
    if (n == 0 || n > MAX_FRAME_LEN ||
        (level < n && (req.cmd == frfifo_pkg::OP_READ || level == 0))) begin
      pending_results.push_back(res);
      return;
    end
    if (level < n)
      n = level;
    for (int i = 0; i < n; i++) begin
      res            = '0;
      res.out_byte   = ring_mem[(ring_rd_ptr + i) % RING_DEPTH];
      res.byte_valid = 1'b1;
      res.done_count = 7'(n);
      res.last       = (i == n - 1);
      pending_results.push_back(res);
    end
    if (req.cmd == frfifo_pkg::OP_READ)
      ring_rd_ptr = (ring_rd_ptr + n) % RING_DEPTH;
  endfunction

  // receiver: random pop stalls
  always @(posedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= sink_stall_pct);
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin : scoreboard
    frfifo_pkg::out_t want;
    if (rst_n && push && !full)
      compute_ring_results(in_data);
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transaction with none expected: byte %h valid %b count %0d",
                   $time, out_data.out_byte, out_data.byte_valid, out_data.done_count);
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_byte    !== want.out_byte    ||
            out_data.byte_valid  !== want.byte_valid  ||
            out_data.done_count  !== want.done_count  ||
            out_data.is_empty    !== want.is_empty    ||
            out_data.available   !== want.available   ||
            out_data.frame_ready !== want.frame_ready ||
            out_data.last        !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch", $time);
            $display("  expected byte %h valid %b count %0d empty %b avail %0d ready %b last %b",
                     want.out_byte, want.byte_valid, want.done_count, want.is_empty,
                     want.available, want.frame_ready, want.last);
            $display("  actual   byte %h valid %b count %0d empty %b avail %0d ready %b last %b",
                     out_data.out_byte, out_data.byte_valid, out_data.done_count,
                     out_data.is_empty, out_data.available, out_data.frame_ready,
                     out_data.last);
          end
        end
      end
    end
  end

  // one request transaction, with random sender gaps
  task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                           input logic [6:0] len);
    frfifo_pkg::in_t req;
    req.cmd       = op;
    req.wr_byte   = data;
    req.frame_len = len;
    while ($urandom_range(99) < src_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (full)
      @(posedge clk);
    items_sent++;
  endtask

  // read, peek or status with a length biased toward the fill level
  task automatic send_query(input logic [1:0] op);
    int level;
    int pick;
    int len;
    level = ring_level();
    pick  = $urandom_range(9);
    if (pick < 5)
      len = $urandom_range(1, 16);
    else if (pick < 8)
      len = (level == 0) ? 1 : ((level > MAX_FRAME_LEN) ? MAX_FRAME_LEN : level);
    else
      len = $urandom_range(0, 127);
    send_item(op, 8'($urandom), 7'(len));
  endtask

  // whole write frame, other requests mixed in between bytes
  task automatic send_frame(input int len, input int mix_pct);
    int pick;
    send_item(frfifo_pkg::OP_WRITE, 8'($urandom), 7'(len));
    for (int k = 1; k < len; k++) begin
      if ($urandom_range(99) < mix_pct) begin
        pick = $urandom_range(2);
        send_query((pick == 0) ? frfifo_pkg::OP_READ :
                   ((pick == 1) ? frfifo_pkg::OP_PEEK : frfifo_pkg::OP_STATUS));
      end
      send_item(frfifo_pkg::OP_WRITE, 8'($urandom), 7'($urandom));
    end
  endtask

  // empty ring, zero and oversize lengths
  task automatic test_empty_ring_requests();
    send_item(frfifo_pkg::OP_STATUS, 8'h00, 7'd0);
    send_item(frfifo_pkg::OP_STATUS, 8'hFF, 7'd1);
    send_item(frfifo_pkg::OP_READ,   8'h00, 7'd1);
    send_item(frfifo_pkg::OP_PEEK,   8'hFF, 7'd1);
    send_item(frfifo_pkg::OP_WRITE,  8'hFF, 7'd0);
    send_item(frfifo_pkg::OP_READ,   8'h00, 7'd0);
    send_item(frfifo_pkg::OP_PEEK,   8'h00, 7'd0);
    send_item(frfifo_pkg::OP_READ,   8'hFF, 7'd127);
    send_item(frfifo_pkg::OP_PEEK,   8'h00, 7'd65);
  endtask

  // short frames, reduced peek, requests inside a frame, short read
  task automatic test_short_frames();
    send_item(frfifo_pkg::OP_WRITE,  8'h00, 7'd3);
    send_item(frfifo_pkg::OP_WRITE,  8'hFF, 7'h7F);
    send_item(frfifo_pkg::OP_WRITE,  8'h5A, 7'h00);
    send_item(frfifo_pkg::OP_STATUS, 8'h00, 7'd3);
    send_item(frfifo_pkg::OP_STATUS, 8'h00, 7'd4);
    send_item(frfifo_pkg::OP_PEEK,   8'h00, 7'd5);
    send_item(frfifo_pkg::OP_WRITE,  8'hC3, 7'd2);
    send_item(frfifo_pkg::OP_STATUS, 8'h00, 7'd0);
    send_item(frfifo_pkg::OP_PEEK,   8'h00, 7'd64);
    send_item(frfifo_pkg::OP_WRITE,  8'h3C, 7'd9);
    send_item(frfifo_pkg::OP_READ,   8'h00, 7'd6);
    send_item(frfifo_pkg::OP_READ,   8'h00, 7'd5);
    send_item(frfifo_pkg::OP_STATUS, 8'h00, 7'd0);
  endtask

  // oversize drop, fill to capacity, drops on no room, drain with wrap
  task automatic test_ring_full();
    send_frame($urandom_range(65, 72), 0);
    repeat (4)
      send_frame(MAX_FRAME_LEN, 0);
    send_frame(RING_DEPTH - 1 - 3 * MAX_FRAME_LEN, 0);
    send_frame(1, 0);
    send_item(frfifo_pkg::OP_STATUS, 8'h00, 7'd64);
    send_item(frfifo_pkg::OP_PEEK,   8'h00, 7'd64);
    repeat (3)
      send_item(frfifo_pkg::OP_READ, 8'h00, 7'd64);
    send_item(frfifo_pkg::OP_READ,   8'h00, 7'd63);
    send_item(frfifo_pkg::OP_STATUS, 8'h00, 7'd1);
  endtask

  // random frames and requests, plus some noise
  task automatic test_random_traffic(input int goal);
    int stop_at;
    int pick;
    int len;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        pick = $urandom_range(99);
        if (pick < 4)
          len = 0;
        else if (pick < 7)
          len = $urandom_range(65, 127);
        else if (pick < 22)
          len = $urandom_range(9, MAX_FRAME_LEN);
        else
          len = $urandom_range(1, 8);
        send_frame(len, 10);
      end else if (pick < 65) begin
        send_query(frfifo_pkg::OP_READ);
      end else if (pick < 80) begin
        send_query(frfifo_pkg::OP_PEEK);
      end else if (pick < 92) begin
        send_query(frfifo_pkg::OP_STATUS);
      end else begin
        send_item(2'($urandom), 8'($urandom), 7'($urandom));
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    src_gap_pct    = 11;
    sink_stall_pct = 69;
    test_empty_ring_requests();
    test_short_frames();
    test_ring_full();
    test_random_traffic(20);

    src_gap_pct    = 69;
    sink_stall_pct = 11;
    test_random_traffic(20);

    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_traffic(20);

    push <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
